### rtl/lra_pkg.sv
// shared constants and controller/datapath command and status types
package lra_pkg;

    localparam int GROUP_LIMIT = 8;
    localparam int AMT_W       = 16;
    localparam int WGT_W       = 16;
    localparam int SHARE_W     = 16;
    localparam int GIDX_W      = 3;
    localparam int IDX_W       = (GROUP_LIMIT > 1) ? $clog2(GROUP_LIMIT) : 1;
    localparam int CNT_W       = $clog2(GROUP_LIMIT + 1);
    localparam int K_W         = (IDX_W > GIDX_W) ? IDX_W : GIDX_W;
    localparam int SUM_W       = WGT_W + IDX_W;
    localparam int PROD_W      = AMT_W + WGT_W;
    localparam int BIT_W       = $clog2(SHARE_W);

    typedef struct packed {
        logic load;
        logic start;
        logic mul;
        logic div;
        logic store;
        logic scan;
        logic award;
        logic emit_ld;
        logic clear;
        logic k_inc;
        logic k_clr;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic last_k;
        logic div_last;
        logic left_zero;
    } t_stat;

endpackage

### rtl/lra_if.sv
// valid/ready channel interfaces for input weights and output shares
interface lra_in_if;
    import lra_pkg::*;
    logic               valid;
    logic               ready;
    logic [AMT_W-1:0]   amount;
    logic [WGT_W-1:0]   weight;
    logic               final_weight;
    modport source (output valid, output amount, output weight, output final_weight,
                    input ready);
    modport sink   (input valid, input amount, input weight, input final_weight,
                    output ready);
endinterface

interface lra_out_if;
    import lra_pkg::*;
    logic               valid;
    logic               ready;
    logic [SHARE_W-1:0] share;
    logic [GIDX_W-1:0]  group_index;
    logic               final_share;
    logic               error;
    modport source (output valid, output share, output group_index, output final_share,
                    output error, input ready);
    modport sink   (input valid, input share, input group_index, input final_share,
                    input error, output ready);
endinterface

### rtl/lra_datapath.sv
// weight store, multiply, bit-serial divider, remainder search and output register
module lra_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lra_pkg::t_cmd           i_cmd,
    output lra_pkg::t_stat          o_stat,
    input  logic [lra_pkg::AMT_W-1:0]   i_amount,
    input  logic [lra_pkg::WGT_W-1:0]   i_weight,
    output logic [lra_pkg::SHARE_W-1:0] o_share,
    output logic [lra_pkg::GIDX_W-1:0]  o_group_index,
    output logic                        o_final_share,
    output logic                        o_error
);
    import lra_pkg::*;

    logic [WGT_W-1:0]   r_weight [GROUP_LIMIT];
    logic [SHARE_W-1:0] r_share  [GROUP_LIMIT];
    logic [SUM_W-1:0]   r_rem    [GROUP_LIMIT];
    logic [SUM_W-1:0]   r_sum;
    logic [AMT_W-1:0]   r_amount;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [K_W-1:0]     r_k;
    logic [SUM_W-1:0]   r_drem;
    logic [SHARE_W-1:0] r_dlow;
    logic [SHARE_W-1:0] r_quo;
    logic [BIT_W-1:0]   r_bit;
    logic [AMT_W-1:0]   r_left;
    logic [IDX_W-1:0]   r_best;
    logic [SUM_W-1:0]   r_best_rem;
    logic [SHARE_W-1:0] r_best_share;
    logic [SHARE_W-1:0] r_o_share;
    logic [GIDX_W-1:0]  r_o_idx;
    logic               r_o_final;
    logic               r_o_err;

    logic [IDX_W-1:0]   k_idx;
    logic [PROD_W-1:0]  n_prod;
    logic [SUM_W:0]     n_trial;
    logic               n_qbit;
    logic               err;
    logic               last_k;
    logic               better;

    assign k_idx   = r_k[IDX_W-1:0];
    assign n_prod  = PROD_W'(r_amount) * PROD_W'(r_weight[k_idx]);
    assign n_trial = {r_drem, r_dlow[SHARE_W-1]};
    assign n_qbit  = n_trial >= {1'b0, r_sum};
    assign err     = r_ovf || (r_sum == '0);
    assign last_k  = (CNT_W'(r_k) + CNT_W'(1)) == r_count;
    assign better  = (r_rem[k_idx] > r_best_rem) ||
                     ((r_rem[k_idx] == r_best_rem) && (r_share[k_idx] < r_best_share));

    assign o_stat.err       = err;
    assign o_stat.last_k    = last_k;
    assign o_stat.div_last  = r_bit == BIT_W'(SHARE_W - 1);
    assign o_stat.left_zero = r_left == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_amount <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_k      <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_count == '0 && !r_ovf) begin
                    r_amount <= i_amount;
                end
                if (r_count < CNT_W'(GROUP_LIMIT)) begin
                    r_sum   <= r_sum + SUM_W'(i_weight);
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_sum    <= '0;
                r_amount <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CNT_W'(GROUP_LIMIT)) begin
            r_weight[r_count[IDX_W-1:0]] <= i_weight;
        end
        if (i_cmd.start) begin
            r_left <= r_amount;
        end
        // product split: upper half is below the sum, lower half shifts in
        if (i_cmd.mul) begin
            r_drem <= SUM_W'(n_prod[PROD_W-1:SHARE_W]);
            r_dlow <= n_prod[SHARE_W-1:0];
            r_bit  <= '0;
        end
        if (i_cmd.div) begin
            r_drem <= n_qbit ? SUM_W'(n_trial - {1'b0, r_sum}) : SUM_W'(n_trial);
            r_dlow <= {r_dlow[SHARE_W-2:0], 1'b0};
            r_quo  <= {r_quo[SHARE_W-2:0], n_qbit};
            r_bit  <= r_bit + BIT_W'(1);
        end
        if (i_cmd.store) begin
            r_share[k_idx] <= r_quo;
            r_rem[k_idx]   <= r_drem;
            r_left         <= r_left - r_quo;
        end
        if (i_cmd.scan && (r_k == '0 || better)) begin
            r_best       <= k_idx;
            r_best_rem   <= r_rem[k_idx];
            r_best_share <= r_share[k_idx];
        end
        if (i_cmd.award) begin
            r_share[r_best] <= r_share[r_best] + SHARE_W'(1);
            r_rem[r_best]   <= '0;
            r_left          <= r_left - AMT_W'(1);
        end
        if (i_cmd.emit_ld) begin
            r_o_share <= err ? '0 : r_share[k_idx];
            r_o_idx   <= r_k[GIDX_W-1:0];
            r_o_final <= last_k;
            r_o_err   <= err;
        end
    end

    assign o_share       = r_o_share;
    assign o_group_index = r_o_idx;
    assign o_final_share = r_o_final;
    assign o_error       = r_o_err;

endmodule

### rtl/lra_ctrl.sv
// sequencing state machine for load, divide, remainder award and emit phases
module lra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_final,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lra_pkg::t_cmd   o_cmd,
    input  lra_pkg::t_stat  i_stat
);
    import lra_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_START, S_MUL, S_DIV, S_STORE, S_CHECK, S_SCAN, S_AWARD, S_EMIT_LD, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_final) n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = i_stat.err ? S_EMIT_LD : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_last) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_stat.last_k) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_CHECK: begin
                n_state = i_stat.left_zero ? S_EMIT_LD : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.last_k) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_AWARD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_AWARD: begin
                o_cmd.award = 1'b1;
                n_state = S_CHECK;
            end
            S_EMIT_LD: begin
                o_cmd.emit_ld = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (i_stat.last_k) begin
                        o_cmd.clear = 1'b1;
                        o_cmd.k_clr = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state = S_EMIT_LD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_LOAD;
    assign o_out_valid = r_out_valid;

endmodule

### rtl/largest_remainder_apportioner.sv
// Splits an amount among up to GROUP_LIMIT groups by largest remainder. Weights load one
// word per cycle; the amount comes from the first word of a set and the word with
// final_weight closes it. After the close the block takes no input until all shares are
// out: a start step, then per group a multiply step, the bit-serial divider and a store
// step, then for each leftover unit (fewer than the group count) a check, a scan over
// every group and an award, and a last check once nothing is left; each share then
// passes through the output register and waits there while the receiver stalls. On error
// (zero weight sum or too many groups) the division phase is skipped and every share
// reads zero.
module largest_remainder_apportioner (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lra_in_if.sink    i_in,
    lra_out_if.source o_out
);
    import lra_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_final  (i_in.final_weight),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    lra_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_amount      (i_in.amount),
        .i_weight      (i_in.weight),
        .o_share       (o_out.share),
        .o_group_index (o_out.group_index),
        .o_final_share (o_out.final_share),
        .o_error       (o_out.error)
    );

endmodule

### rtl/lra_checker.sv
// port-level checks for the apportioner, bound to the top level
module lra_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [lra_pkg::SHARE_W-1:0] i_share,
    input logic                       i_final_share,
    input logic                       i_error
);
    import lra_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_share) && i_out_valid)
        else $error("output word changed while stalled");

    // no input taken while shares are pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready during emit");

    // last share ends the set
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_final_share |=> !i_out_valid && i_in_ready)
        else $error("output continued after final share");

    // an errored set gives nothing
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> i_share == '0)
        else $error("nonzero share with error");

endmodule

bind largest_remainder_apportioner lra_checker u_lra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_share       (o_out.share),
    .i_final_share (o_out.final_share),
    .i_error       (o_out.error)
);

### verif/lra_share_checker.sv
// checker that predicts the share words of each weight set and compares them with the block
module lra_share_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lra_in_if    i_in,
    lra_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_share_count,
    output int   o_set_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lra_pkg::*;

    typedef struct packed {
        logic [SHARE_W-1:0] share;
        logic [GIDX_W-1:0]  group_index;
        logic               final_share;
        logic               error;
    } t_share_word;

    t_share_word       pending_shares[$];
    logic [WGT_W-1:0]  set_weights[GROUP_LIMIT];
    logic [SUM_W-1:0]  set_sum;
    logic [AMT_W-1:0]  set_amount;
    int                set_groups;
    bit                set_overflow;

    assign o_pending = pending_shares.size();

    // largest remainder split of the closed set, pushes one word per group
    task automatic apportion_set();
        longint      whole[GROUP_LIMIT];
        longint      frac[GROUP_LIMIT];
        longint      prod;
        longint      left;
        int          best;
        bit          err;
        t_share_word w;
        err = set_overflow || (set_sum == 0);
        left = longint'(set_amount);
        if (!err) begin
            for (int k = 0; k < set_groups; k++) begin
                prod = longint'(set_amount) * longint'(set_weights[k]);
                whole[k] = prod / longint'(set_sum);
                frac[k] = prod - whole[k] * longint'(set_sum);
                left -= whole[k];
            end
            while (left > 0) begin
                best = 0;
                for (int k = 1; k < set_groups; k++) begin
                    if (frac[k] > frac[best] ||
                        (frac[k] == frac[best] && whole[k] < whole[best]))
                        best = k;
                end
                whole[best] += 1;
                frac[best] = 0;
                left--;
            end
        end
        for (int k = 0; k < set_groups; k++) begin
            w.share       = err ? '0 : SHARE_W'(whole[k]);
            w.group_index = GIDX_W'(k);
            w.final_share = (k + 1 == set_groups);
            w.error       = err;
            pending_shares.push_back(w);
        end
        set_sum      = '0;
        set_amount   = '0;
        set_groups   = 0;
        set_overflow = 0;
    endtask

    always @(posedge i_clk) begin
        t_share_word want;
        if (!i_rst_n) begin
            set_sum       = '0;
            set_amount    = '0;
            set_groups    = 0;
            set_overflow  = 0;
            o_fail_count  = 0;
            o_share_count = 0;
            o_set_count   = 0;
            pending_shares.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (set_groups == 0 && !set_overflow)
                    set_amount = i_in.amount;
                if (set_groups < GROUP_LIMIT) begin
                    set_weights[set_groups] = i_in.weight;
                    set_sum += SUM_W'(i_in.weight);
                    set_groups++;
                end else begin
                    set_overflow = 1;
                end
                if (i_in.final_weight) begin
                    apportion_set();
                    o_set_count++;
                end
            end
            if (i_out.valid && i_out.ready) begin
                o_share_count++;
                if (pending_shares.size() == 0) begin
                    $error("share word with nothing expected: share %0d group %0d",
                           i_out.share, i_out.group_index);
                    o_fail_count++;
                end else begin
                    want = pending_shares.pop_front();
                    if (i_out.share !== want.share) begin
                        $error("share: expected %0d, got %0d", want.share, i_out.share);
                        o_fail_count++;
                    end
                    if (i_out.group_index !== want.group_index) begin
                        $error("group_index: expected %0d, got %0d",
                               want.group_index, i_out.group_index);
                        o_fail_count++;
                    end
                    if (i_out.final_share !== want.final_share) begin
                        $error("final_share: expected %0d, got %0d",
                               want.final_share, i_out.final_share);
                        o_fail_count++;
                    end
                    if (i_out.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, i_out.error);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

### verif/largest_remainder_apportioner_test.sv
// top of the apportioner testbench: clock, reset, weight stimulus, idling and verdict
module largest_remainder_apportioner_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lra_pkg::*;

    localparam int IDLE_LIMIT = 6000;

    logic i_clk = 0;
    logic i_rst_n = 0;

    lra_in_if  in_ch();
    lra_out_if out_ch();

    int fail_count, pending, share_count, set_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int words_sent = 0;
    int quiet_cycles = 0;

    largest_remainder_apportioner DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    lra_share_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_share_count(share_count),
        .o_set_count  (set_count)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.amount = '0;
        in_ch.weight = '0;
        in_ch.final_weight = 0;
        out_ch.ready = 0;
    end

    // receiver: random stalls, or a long counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready = 0;
            hold_cycles--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no word moving", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_word(input logic [AMT_W-1:0] amt, input logic [WGT_W-1:0] wgt,
                             input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 0;
            @(negedge i_clk);
        end
        in_ch.amount = amt;
        in_ch.weight = wgt;
        in_ch.final_weight = fin;
        in_ch.valid = 1;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // mode 0 full-range weights, 1 small weights, 2 all zero, 3 equal weights
    task automatic send_set(input logic [AMT_W-1:0] amt, input int n, input int mode);
        logic [WGT_W-1:0] wgt;
        logic [WGT_W-1:0] same;
        same = WGT_W'($urandom_range(1, 65535));
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: wgt = WGT_W'($urandom);
                1: wgt = WGT_W'($urandom_range(0, 7));
                2: wgt = '0;
                default: wgt = same;
            endcase
            send_word(k == 0 ? amt : AMT_W'($urandom), wgt, k == n - 1);
        end
    endtask

    task automatic random_sets(input int words);
        int stop_at;
        int n;
        int pick;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            n = (pick < 8) ? $urandom_range(9, 11) : $urandom_range(1, GROUP_LIMIT);
            if (pick >= 8 && pick < 14)
                send_set(AMT_W'($urandom), n, 2);
            else if (pick < 60)
                send_set(AMT_W'($urandom), n, 0);
            else if (pick < 80)
                send_set(AMT_W'($urandom_range(0, 40)), n, 1);
            else
                send_set(AMT_W'($urandom), n, 3);
        end
        in_ch.valid = 0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed sets
        send_set(16'hFFFF, GROUP_LIMIT, 3);
        send_word(16'hFFFF, 16'hFFFF, 1);
        send_word(16'd0, 16'd5, 0);
        send_word(16'd9, 16'd0, 1);
        send_set(16'd100, 3, 2);
        send_word(16'd10, 16'd1, 0);
        send_word(16'd0, 16'd1, 0);
        send_word(16'd0, 16'd1, 1);
        send_word(16'd7, 16'd3, 0);
        send_word(16'd0, 16'd1, 0);
        send_word(16'd0, 16'd1, 1);
        send_set(16'd1234, GROUP_LIMIT + 2, 0);
        in_ch.valid = 0;

        // pause until everything has drained
        wait (pending == 0);
        @(negedge i_clk);

        // long receiver hold-off while words keep coming
        hold_cycles = 400;
        random_sets(20);
        wait (pending == 0);
        @(negedge i_clk);

        random_sets(70);
        send_idle_pct = 57;
        random_sets(70);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        random_sets(70);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        random_sets(70);

        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d weight words in %0d sets, %0d share words checked",
                 words_sent, set_count, share_count);
        $display("sets included zero sums, overflowing sets, ties and long output stalls");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/lra_pkg.sv
rtl/lra_if.sv
rtl/lra_datapath.sv
rtl/lra_ctrl.sv
rtl/largest_remainder_apportioner.sv
rtl/lra_checker.sv
verif/lra_share_checker.sv
verif/largest_remainder_apportioner_test.sv
